FILE: hdl/bts_pkg.sv
// Package: types, constants and helpers shared by the transfer splitter modules.
package bts_pkg;

  localparam int MAX_STEP_LOG2 = 6;
  localparam int MIN_STEP_LOG2 = 3;
  localparam int COUNT_BITS    = 12;
  localparam int LOG2_BITS     = 3;
  localparam int LIMIT_BITS    = 9;
  localparam int OFF_BITS      = 9;
  localparam int NXT_BITS      = OFF_BITS + 1;
  localparam int BYTES_BITS    = MAX_STEP_LOG2 + 1;
  localparam int MSB_BITS      = $clog2(OFF_BITS);
  localparam int WORD_BYTES    = 8;
  localparam int WORD_BITS     = 8 * WORD_BYTES;
  localparam int VEC_BYTES     = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = LIMIT_BITS;
  localparam int FIFO_DEPTH    = 2;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int FCNT_BITS     = PTR_BITS + 1;

  localparam logic [LOG2_BITS-1:0]  STEP_LOG2_RST = LOG2_BITS'(4);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RST     = LIMIT_BITS'(128);

  localparam logic [CFG_ADDR_BITS-1:0] CFG_COPY_STEP  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FILL_STEP  = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COPY_LIMIT = CFG_ADDR_BITS'(2);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FILL_LIMIT = CFG_ADDR_BITS'(3);

  typedef enum logic [1:0] {
    ACT_STEP   = 2'd0,
    ACT_KEEP   = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef struct packed {
    action_e                kind;
    logic                   fill;
    logic [7:0]             fill_byte;
    logic [OFF_BITS-1:0]    count;
    logic [LOG2_BITS-1:0]   wlog;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [WORD_BITS-1:0] replicate(input logic [7:0] pat,
                                                     input logic [BYTES_BITS-1:0] nbytes);
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (nbytes > BYTES_BITS'(i)) begin
        w[8*i +: 8] = pat;
      end
    end
    return w;
  endfunction

endpackage

FILE: hdl/bts_intf.sv
// Interfaces: request, result and configuration channels.
interface bts_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bts_pkg::COUNT_BITS-1:0] byte_count;
  logic [7:0]                    fill_byte;

  modport source (output valid, command, byte_count, fill_byte, input ready);
  modport sink   (input valid, command, byte_count, fill_byte, output ready);
endinterface

interface bts_rsp_if;
  logic                            valid;
  logic                            ready;
  bts_pkg::action_e                action;
  logic [bts_pkg::OFF_BITS-1:0]    step_offset;
  logic [bts_pkg::BYTES_BITS-1:0]  step_bytes;
  logic                            is_vector;
  logic [bts_pkg::WORD_BITS-1:0]   fill_word;
  logic                            last;

  modport source (output valid, action, step_offset, step_bytes, is_vector, fill_word, last,
                  input ready);
  modport sink   (input valid, action, step_offset, step_bytes, is_vector, fill_word, last,
                  output ready);
endinterface

interface bts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bts_pkg::CFG_ADDR_BITS-1:0] addr;
  logic [bts_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: hdl/block_transfer_splitter.sv
// Top level: copy/fill request splitter into power-of-two transfers.
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  command, byte_count, fill_byte
//   rsp      out  valid/ready  action, step_offset, step_bytes, is_vector, fill_word, last
//   cfg      in   valid/ready  addr (register index), data
//
// A request yields one result per cycle from the step sequencer while the output is not
// stalled: a keep or remove request gives a single result, a split request one result per transfer (1 to 64).
// A two-entry descriptor queue lets requests be taken while the sequencer works.
// A stalled result holds in the output register; the sequencer waits on it.
// Reset loads the configuration defaults and empties the queue; cfg is always ready.
module block_transfer_splitter (
  input  logic      clk_i,
  input  logic      rst_ni,
  bts_req_if.sink   req,
  bts_rsp_if.source rsp,
  bts_cfg_if.sink   cfg
);
  import bts_pkg::*;

  desc_t      desc;
  desc_t      head;
  fifo_stat_t stat;
  logic       push;
  logic       pop;

  bts_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .cfg    (cfg),
    .full_i (stat.full),
    .push_o (push),
    .desc_o (desc)
  );

  bts_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  bts_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .rsp    (rsp)
  );

endmodule

FILE: hdl/bts_front.sv
// Front end: configuration registers and request classification.
module bts_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bts_req_if.sink        req,
  bts_cfg_if.sink        cfg,
  input  logic           full_i,
  output logic           push_o,
  output bts_pkg::desc_t desc_o
);
  import bts_pkg::*;

  logic [LOG2_BITS-1:0]  copy_step_q, copy_step_d;
  logic [LOG2_BITS-1:0]  fill_step_q, fill_step_d;
  logic [LIMIT_BITS-1:0] copy_limit_q, copy_limit_d;
  logic [LIMIT_BITS-1:0] fill_limit_q, fill_limit_d;

  logic [LIMIT_BITS-1:0] limit;
  logic [LOG2_BITS-1:0]  lg_raw;
  logic [LOG2_BITS-1:0]  lg;
  logic [OFF_BITS-1:0]   cnt;
  logic [MSB_BITS-1:0]   msb;

  assign cfg.ready = 1'b1;

  always_comb begin
    copy_step_d  = copy_step_q;
    fill_step_d  = fill_step_q;
    copy_limit_d = copy_limit_q;
    fill_limit_d = fill_limit_q;
    if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_COPY_STEP:  copy_step_d  = cfg.data[LOG2_BITS-1:0];
        CFG_FILL_STEP:  fill_step_d  = cfg.data[LOG2_BITS-1:0];
        CFG_COPY_LIMIT: copy_limit_d = cfg.data[LIMIT_BITS-1:0];
        CFG_FILL_LIMIT: fill_limit_d = cfg.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_step_q  <= STEP_LOG2_RST;
      fill_step_q  <= STEP_LOG2_RST;
      copy_limit_q <= LIMIT_RST;
      fill_limit_q <= LIMIT_RST;
    end else begin
      copy_step_q  <= copy_step_d;
      fill_step_q  <= fill_step_d;
      copy_limit_q <= copy_limit_d;
      fill_limit_q <= fill_limit_d;
    end
  end

  always_comb begin
    limit  = req.command ? fill_limit_q : copy_limit_q;
    lg_raw = req.command ? fill_step_q : copy_step_q;
    priority if (lg_raw < LOG2_BITS'(MIN_STEP_LOG2)) lg = LOG2_BITS'(MIN_STEP_LOG2);
    else if (lg_raw > LOG2_BITS'(MAX_STEP_LOG2))     lg = LOG2_BITS'(MAX_STEP_LOG2);
    else                                              lg = lg_raw;

    cnt = req.byte_count[OFF_BITS-1:0];
    msb = '0;
    for (int i = 0; i < OFF_BITS; i++) begin
      if (cnt[i]) msb = MSB_BITS'(i);
    end

    desc_o.fill      = req.command;
    desc_o.fill_byte = req.fill_byte;
    desc_o.count     = cnt;
    desc_o.wlog      = (MSB_BITS'(lg) < msb) ? lg : msb[LOG2_BITS-1:0];
    priority if (req.byte_count > COUNT_BITS'(limit)) desc_o.kind = ACT_KEEP;
    else if (req.byte_count == '0)                   desc_o.kind = ACT_REMOVE;
    else                                              desc_o.kind = ACT_STEP;
  end

  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i;

endmodule

FILE: hdl/bts_fifo.sv
// Descriptor queue between the front end and the step sequencer.
module bts_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bts_pkg::desc_t      desc_i,
  input  logic                pop_i,
  output bts_pkg::desc_t      head_o,
  output bts_pkg::fifo_stat_t stat_o
);
  import bts_pkg::*;

  desc_t                mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_q, wr_d;
  logic [PTR_BITS-1:0]  rd_q, rd_d;
  logic [FCNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FCNT_BITS'(FIFO_DEPTH));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FCNT_BITS'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: hdl/bts_back.sv
// Back end: walks one descriptor into transfer results, one per cycle while the output is not stalled.
module bts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bts_pkg::desc_t      head_i,
  input  bts_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  bts_rsp_if.source           rsp
);
  import bts_pkg::*;

  logic [OFF_BITS-1:0]   off_q, off_d;
  logic                  valid_q, valid_d;
  action_e               action_q, action_d;
  logic [OFF_BITS-1:0]   offset_q, offset_d;
  logic [BYTES_BITS-1:0] bytes_q, bytes_d;
  logic [WORD_BITS-1:0]  word_q, word_d;
  logic                  last_q, last_d;

  logic                  adv;
  logic [BYTES_BITS-1:0] w;
  logic [NXT_BITS-1:0]   nxt;
  logic [OFF_BITS-1:0]   rem;
  logic                  fits;
  logic                  rem_pow2;

  assign adv = !valid_q || rsp.ready;

  always_comb begin
    w        = BYTES_BITS'(1) << head_i.wlog;
    nxt      = NXT_BITS'(off_q) + NXT_BITS'(w);
    fits     = nxt <= NXT_BITS'(head_i.count);
    rem      = head_i.count - off_q;
    rem_pow2 = (rem & (rem - 1'b1)) == '0;

    off_d    = off_q;
    valid_d  = valid_q && !rsp.ready;
    action_d = action_q;
    offset_d = offset_q;
    bytes_d  = bytes_q;
    word_d   = word_q;
    last_d   = last_q;
    pop_o    = 1'b0;

    if (adv && !stat_i.empty) begin
      valid_d  = 1'b1;
      action_d = head_i.kind;
      if (head_i.kind != ACT_STEP) begin
        offset_d = '0;
        bytes_d  = '0;
        last_d   = 1'b1;
      end else if (fits) begin
        offset_d = off_q;
        bytes_d  = w;
        last_d   = (nxt == NXT_BITS'(head_i.count));
      end else if (rem_pow2) begin
        offset_d = off_q;
        bytes_d  = rem[BYTES_BITS-1:0];
        last_d   = 1'b1;
      end else begin
        offset_d = head_i.count - OFF_BITS'(w);
        bytes_d  = w;
        last_d   = 1'b1;
      end
      word_d = head_i.fill ? replicate(head_i.fill_byte, bytes_d) : '0;
      if (last_d) begin
        pop_o = 1'b1;
        off_d = '0;
      end else begin
        off_d = nxt[OFF_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      off_q   <= off_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    offset_q <= offset_d;
    bytes_q  <= bytes_d;
    word_q   <= word_d;
    last_q   <= last_d;
  end

  assign rsp.valid       = valid_q;
  assign rsp.action      = action_q;
  assign rsp.step_offset = offset_q;
  assign rsp.step_bytes  = bytes_q;
  assign rsp.is_vector   = bytes_q >= BYTES_BITS'(VEC_BYTES);
  assign rsp.fill_word   = word_q;
  assign rsp.last        = last_q;

  a_off_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.empty |-> off_q == '0)
    else $error("step offset left over with no request pending");

  a_off_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty && head_i.kind == ACT_STEP |-> off_q < head_i.count)
    else $error("step offset past end of region");

  a_step_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && action_q == ACT_STEP |-> $onehot(bytes_q))
    else $error("transfer width not a power of two");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && action_q != ACT_STEP |-> last_q && bytes_q == '0)
    else $error("keep or remove result malformed");

endmodule

FILE: tb/tb_block_transfer_splitter.sv
// Testbench for block_transfer_splitter: random copy/fill requests against a scoreboard.
`timescale 1ns / 100ps

module tb_block_transfer_splitter;
  import bts_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    action_e               action;
    logic [OFF_BITS-1:0]   offset;
    logic [BYTES_BITS-1:0] nbytes;
    logic                  vec;
    logic [WORD_BITS-1:0]  word;
    logic                  last;
  } xfer_t;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_BURSTY} rdy_mode_e;

  class transfer_scoreboard;
    xfer_t expected_q[$];
    int    errors;
    int    copy_lg, fill_lg, copy_lim, fill_lim;

    function new();
      errors   = 0;
      copy_lg  = int'(STEP_LOG2_RST);
      fill_lg  = int'(STEP_LOG2_RST);
      copy_lim = int'(LIMIT_RST);
      fill_lim = int'(LIMIT_RST);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_COPY_STEP:  copy_lg  = int'(data[LOG2_BITS-1:0]);
        CFG_FILL_STEP:  fill_lg  = int'(data[LOG2_BITS-1:0]);
        CFG_COPY_LIMIT: copy_lim = int'(data);
        CFG_FILL_LIMIT: fill_lim = int'(data);
        default: ;
      endcase
    endfunction

    function void add_transfer(action_e act, int off, int nb, bit fill, logic [7:0] pat,
                               bit last);
      xfer_t t;
      int    i;
      t.action = act;
      t.offset = OFF_BITS'(off);
      t.nbytes = BYTES_BITS'(nb);
      t.vec    = (nb >= VEC_BYTES);
      t.word   = '0;
      if (fill) begin
        for (i = 0; i < WORD_BYTES; i++) begin
          if (i < nb) t.word[8*i +: 8] = pat;
        end
      end
      t.last = last;
      expected_q.push_back(t);
    endfunction

    // Expands one accepted request into its expected transactions.
    function void note_request(bit fill, int count, logic [7:0] pat);
      int lim, lg, width, off, rem;
      lim = fill ? fill_lim : copy_lim;
      lg  = fill ? fill_lg : copy_lg;
      if (lg < MIN_STEP_LOG2) lg = MIN_STEP_LOG2;
      if (lg > MAX_STEP_LOG2) lg = MAX_STEP_LOG2;
      if (count > lim) begin
        add_transfer(ACT_KEEP, 0, 0, 1'b0, 8'h00, 1'b1);
      end else if (count == 0) begin
        add_transfer(ACT_REMOVE, 0, 0, 1'b0, 8'h00, 1'b1);
      end else begin
        width = 1 << lg;
        while (width > count) width = width >> 1;
        off = 0;
        while (off + width <= count) begin
          add_transfer(ACT_STEP, off, width, fill, pat, (off + width) == count);
          off = off + width;
        end
        rem = count - off;
        if (rem != 0) begin
          if ((rem & (rem - 1)) == 0) begin
            add_transfer(ACT_STEP, off, rem, fill, pat, 1'b1);
          end else begin
            // ragged tail: one overlapping full-width step
            add_transfer(ACT_STEP, count - width, width, fill, pat, 1'b1);
          end
        end
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(xfer_t got);
      xfer_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transaction, action", 64'(got.action), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.action !== want.action) report("action", 64'(got.action), 64'(want.action));
      if (got.offset !== want.offset) report("step_offset", 64'(got.offset), 64'(want.offset));
      if (got.nbytes !== want.nbytes) report("step_bytes", 64'(got.nbytes), 64'(want.nbytes));
      if (got.vec !== want.vec) report("is_vector", 64'(got.vec), 64'(want.vec));
      if (got.word !== want.word) report("fill_word", got.word, want.word);
      if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  bts_req_if req_if();
  bts_rsp_if rsp_if();
  bts_cfg_if cfg_if();

  block_transfer_splitter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  transfer_scoreboard sb = new();

  rdy_mode_e rdy_mode  = RDY_RANDOM;
  bit        no_idle   = 1'b0;
  int        burst_left = 0;
  int        hold_ctr  = 0;
  logic [2:0] pat_ctr  = '0;
  int        cycle_count = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    pat_ctr = pat_ctr + 3'd1;
    case (rdy_mode)
      RDY_ALWAYS:   rsp_if.ready = 1'b1;
      RDY_RANDOM:   rsp_if.ready = ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: rsp_if.ready = (pat_ctr < 3'd5);
      default: begin
        if (hold_ctr == 0) begin
          rsp_if.ready = !rsp_if.ready;
          hold_ctr = $urandom_range(1, 6);
        end
        hold_ctr--;
      end
    endcase
  end

  always @(posedge clk) begin
    xfer_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.addr, cfg_if.data);
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.command, int'(req_if.byte_count), req_if.fill_byte);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.action = rsp_if.action;
        got.offset = rsp_if.step_offset;
        got.nbytes = rsp_if.step_bytes;
        got.vec    = rsp_if.is_vector;
        got.word   = rsp_if.fill_word;
        got.last   = rsp_if.last;
        sb.check_result(got);
      end
    end
  end

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
  endtask

  task automatic send_request(bit fill, int count, logic [7:0] pat);
    if (burst_left == 0) begin
      if (!no_idle) pause_sender($urandom_range(0, 6));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    req_if.valid      = 1'b1;
    req_if.command    = fill;
    req_if.byte_count = COUNT_BITS'(count);
    req_if.fill_byte  = pat;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, int data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.addr  = idx;
    cfg_if.data  = CFG_DATA_BITS'(data);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic configure(int copy_lg, int fill_lg, int copy_lim, int fill_lim);
    write_reg(CFG_COPY_STEP, copy_lg);
    write_reg(CFG_FILL_STEP, fill_lg);
    write_reg(CFG_COPY_LIMIT, copy_lim);
    write_reg(CFG_FILL_LIMIT, fill_lim);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic int pick_count(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 13) return $urandom_range(0, 4095);
    if (r < 20) return lim + $urandom_range(1, 4);
    if (lim == 0) return $urandom_range(0, 8);
    if (r < 27) return lim;
    if (r < 37) return $urandom_range(1, lim);
    return $urandom_range(1, (lim < 48) ? lim : 48);
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 504;
      2:       return 511;
      3:       return $urandom_range(0, 511);
      default: return $urandom_range(1, 130);
    endcase
  endfunction

  task automatic random_request();
    bit        fill;
    int        lim;
    logic [7:0] pat;
    fill = 1'($urandom_range(0, 1));
    lim  = fill ? sb.fill_lim : sb.copy_lim;
    pat  = 8'($urandom_range(0, 255));
    send_request(fill, pick_count(lim), pat);
  endtask

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.command    = 1'b0;
    req_if.byte_count = '0;
    req_if.fill_byte  = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.addr       = '0;
    cfg_if.data       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: empty, over-limit, exact limit, tails
    send_request(1'b0, 0, 8'h00);
    send_request(1'b1, 0, 8'hff);
    send_request(1'b0, 4095, 8'h00);
    send_request(1'b1, 4095, 8'hff);
    send_request(1'b0, 128, 8'h00);
    send_request(1'b0, 129, 8'h00);
    send_request(1'b1, 1, 8'ha5);
    send_request(1'b0, 3, 8'h00);
    send_request(1'b0, 7, 8'h00);
    send_request(1'b1, 12, 8'h5a);
    send_request(1'b1, 24, 8'hff);
    send_request(1'b0, 31, 8'h00);
    send_request(1'b1, 100, 8'h00);
    send_request(1'b0, 16, 8'h00);
    send_request(1'b1, 2, 8'h3c);
    wait_idle();

    // step log2 saturation, widest limits
    configure(0, 7, 504, 511);
    rdy_mode = RDY_BURSTY;
    send_request(1'b0, 504, 8'h00);
    send_request(1'b1, 504, 8'hc3);
    send_request(1'b1, 511, 8'h81);
    send_request(1'b0, 505, 8'h00);
    send_request(1'b1, 512, 8'h7e);
    wait_idle();

    // zero limits
    configure(6, 3, 0, 0);
    rdy_mode = RDY_ALWAYS;
    send_request(1'b0, 0, 8'h00);
    send_request(1'b0, 1, 8'h00);
    send_request(1'b1, 0, 8'h11);
    send_request(1'b1, 4095, 8'hee);
    repeat (16) random_request();
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      if (p == 0) begin
        configure(3, 5, 504, 64);
      end else begin
        configure($urandom_range(0, 7), $urandom_range(0, 7), pick_limit(), pick_limit());
      end
      rdy_mode = rdy_mode_e'($urandom_range(0, 3));
      no_idle  = (p == 2);
      for (int k = 0; k < 47; k++) begin
        if (p == 1 && k == 24) wait_idle();
        random_request();
      end
      wait_idle();
    end

    no_idle = 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
